// ===== design/arvp_pkg.sv =====
// Package for the resample / volume / peak core: widths, register indexes,
// sequencer codes and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package arvp_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int VOL_W      = 7;
	localparam int STEP_W     = 20;
	localparam int RING_CFG_W = 15;
	localparam int INDEX_W    = 14;
	localparam int FRAC_W     = 16;
	localparam int SKIP_W     = 4;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 2;

	localparam int MAX_RING_FRAMES = 16384;
	localparam int MAX_OUTS        = 16;

	// Register indexes on the config port.
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RING_FRAMES = 2'd2;

	localparam logic [VOL_W-1:0]      VOLUME_RESET = 7'd80;
	localparam logic [VOL_W-1:0]      VOLUME_MAX   = 7'd100;
	localparam logic [STEP_W-1:0]     STEP_RESET   = 20'd65536;
	localparam logic [RING_CFG_W-1:0] RING_RESET   = 15'(MAX_RING_FRAMES);
	localparam logic [RING_CFG_W-1:0] RING_MIN     = 15'd2;
	localparam logic [RING_CFG_W-1:0] RING_MAX     = 15'(MAX_RING_FRAMES);

	// x / 100 as (x * RECIP) >> RECIP_SHIFT; exact for x < 2^22
	// since (RECIP*100 - 2^29) * x < 2^29.
	localparam int MAG_W       = 22;
	localparam int RECIP_W     = 23;
	localparam int PROD_W      = MAG_W + RECIP_W;
	localparam int RECIP_SHIFT = 29;
	localparam logic [RECIP_W-1:0] RECIP = 23'd5368710;

	// Sequencer codes.
	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
	localparam logic [ST_W-1:0] ST_MUL_L = 3'd1;
	localparam logic [ST_W-1:0] ST_DIV_L = 3'd2;
	localparam logic [ST_W-1:0] ST_MUL_R = 3'd3;
	localparam logic [ST_W-1:0] ST_DIV_R = 3'd4;
	localparam logic [ST_W-1:0] ST_EMIT  = 3'd5;

	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 96;

endpackage

// ===== design/audio_resample_volume_peak_core.sv =====
// Top level of the nearest-neighbour resampler with volume, scope and peaks.
// Depends on arvp_pkg.
`timescale 1ns / 1ps

// A source frame on the slave stream produces 0..16 output frames on the
// master stream. A frame that makes outputs uses the one shared multiplier
// in turn for left gain, left /100, right gain and right /100, then emits
// its outputs one by one as the master side takes them; the block is not
// ready over that time. A skipped frame or a peak decay tick (tuser bit 0)
// is taken in the idle state and makes no output. A finished output waits
// in the output register; a new frame can be taken while it waits. Config
// writes land at once and are meant for idle periods only. Ring length is
// clamped to 2..16384 in use, volume to 100. The last output of each frame
// carries tlast.
module audio_resample_volume_peak_core (
	input  logic clk,
	input  logic arst_n,
	// config write port
	input  logic                            cfg_we,
	input  logic [arvp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [arvp_pkg::CFG_DATA_W-1:0] cfg_data,
	// source frames
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [arvp_pkg::IN_DATA_W-1:0]  s_tdata,  // left_in[15:0], right_in[31:16]
	input  logic [arvp_pkg::IN_USER_W-1:0]  s_tuser,  // func[0], mono[1], frame_start[2]
	// output frames
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [arvp_pkg::OUT_DATA_W-1:0] m_tdata,  // out_left[15:0], out_right[31:16],
	                                                  // ring_index[45:32], scope[61:46],
	                                                  // peak_left[77:62], peak_right[93:78]
	output logic                            m_tlast
);
	import arvp_pkg::*;

	localparam logic [SKIP_W-1:0] LAST_OUT = 4'(MAX_OUTS - 1);

	// config registers
	logic [VOL_W-1:0]      volume_q;
	logic [STEP_W-1:0]     phase_step_q;
	logic [RING_CFG_W-1:0] ring_frames_q;

	// control state
	logic [ST_W-1:0]    state_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [SKIP_W-1:0]  skip_q;
	logic [INDEX_W-1:0] wr_idx_q;
	logic [SAMPLE_W-1:0] peak_l_q, peak_r_q;
	logic [SKIP_W-1:0]  cnt_q;
	logic               out_valid_q;

	// per-frame working registers
	logic [SAMPLE_W-1:0] abs_l_q, abs_r_q;
	logic                neg_l_q, neg_r_q;
	logic [SAMPLE_W-1:0] scope_q;
	logic [MAG_W-1:0]    mag_q;
	logic [SAMPLE_W-1:0] ql_q, qr_q;

	// output register
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_last_q;

	// input fields
	logic signed [SAMPLE_W-1:0] in_l, in_r, src_r;
	logic in_func, in_mono, in_fstart;
	assign in_l      = s_tdata[SAMPLE_W-1:0];
	assign in_r      = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
	assign in_func   = s_tuser[0];
	assign in_mono   = s_tuser[1];
	assign in_fstart = s_tuser[2];
	assign src_r     = in_mono ? in_l : in_r;

	assign s_tready = (state_q == ST_IDLE);
	logic in_xfer;
	assign in_xfer = s_tvalid && s_tready;

	// scope: (l + r) / 2 toward zero, bias negative sums by one before the shift
	logic [SAMPLE_W:0] sum17, sum_adj;
	assign sum17   = {in_l[SAMPLE_W-1], in_l} + {src_r[SAMPLE_W-1], src_r};
	assign sum_adj = sum17 + {{SAMPLE_W{1'b0}}, sum17[SAMPLE_W]};

	// magnitudes (|-32768| fits in 16 unsigned bits)
	logic [SAMPLE_W-1:0] abs_in_l, abs_in_r;
	assign abs_in_l = in_l[SAMPLE_W-1]  ? SAMPLE_W'(-in_l)  : in_l;
	assign abs_in_r = src_r[SAMPLE_W-1] ? SAMPLE_W'(-src_r) : src_r;

	logic [VOL_W-1:0] vol_eff;
	assign vol_eff = (volume_q > VOLUME_MAX) ? VOLUME_MAX : volume_q;

	// shared multiplier
	logic [MAG_W-1:0]   mul_a;
	logic [RECIP_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic [SAMPLE_W-1:0] quot;
	always_comb begin
		unique case (state_q)
			ST_MUL_L: begin
				mul_a = MAG_W'(abs_l_q);
				mul_b = RECIP_W'(vol_eff);
			end
			ST_MUL_R: begin
				mul_a = MAG_W'(abs_r_q);
				mul_b = RECIP_W'(vol_eff);
			end
			default: begin
				mul_a = mag_q;
				mul_b = RECIP;
			end
		endcase
	end
	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign quot = prod[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];

	// output step
	logic out_free, emit;
	assign out_free = !out_valid_q || m_tready;
	assign emit     = (state_q == ST_EMIT) && out_free;

	logic [SAMPLE_W-1:0] peak_l_nxt, peak_r_nxt, sl, sr;
	assign peak_l_nxt = (ql_q > peak_l_q) ? ql_q : peak_l_q;
	assign peak_r_nxt = (qr_q > peak_r_q) ? qr_q : peak_r_q;
	assign sl = neg_l_q ? SAMPLE_W'(-ql_q) : ql_q;
	assign sr = neg_r_q ? SAMPLE_W'(-qr_q) : qr_q;

	logic [RING_CFG_W-1:0] ring_len, idx_inc;
	always_comb begin
		priority if (ring_frames_q < RING_MIN)
			ring_len = RING_MIN;
		else if (ring_frames_q > RING_MAX)
			ring_len = RING_MAX;
		else
			ring_len = ring_frames_q;
	end
	assign idx_inc = RING_CFG_W'(wr_idx_q) + 15'd1;

	logic [FRAC_W+4:0] phase_sum;
	logic [4:0]        carry;
	logic              done;
	assign phase_sum = {5'd0, frac_q} + {1'b0, phase_step_q};
	assign carry     = phase_sum[FRAC_W+4:FRAC_W];
	assign done      = (carry != 5'd0) || (cnt_q == LAST_OUT);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q      <= VOLUME_RESET;
			phase_step_q  <= STEP_RESET;
			ring_frames_q <= RING_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VOLUME:      volume_q      <= cfg_data[VOL_W-1:0];
				REG_PHASE_STEP:  phase_step_q  <= cfg_data[STEP_W-1:0];
				REG_RING_FRAMES: ring_frames_q <= cfg_data[RING_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frac_q      <= '0;
			skip_q      <= '0;
			wr_idx_q    <= '0;
			peak_l_q    <= '0;
			peak_r_q    <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (in_func) begin
							// decay tick: drop a quarter of each peak
							peak_l_q <= peak_l_q - (peak_l_q >> 2);
							peak_r_q <= peak_r_q - (peak_r_q >> 2);
						end else if (!in_fstart && skip_q != '0) begin
							skip_q <= skip_q - 4'd1;
						end else begin
							skip_q  <= '0;
							cnt_q   <= '0;
							state_q <= ST_MUL_L;
						end
					end
				end
				ST_MUL_L: state_q <= ST_DIV_L;
				ST_DIV_L: state_q <= ST_MUL_R;
				ST_MUL_R: state_q <= ST_DIV_R;
				ST_DIV_R: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit) begin
						peak_l_q <= peak_l_nxt;
						peak_r_q <= peak_r_nxt;
						wr_idx_q <= (idx_inc >= ring_len) ? '0 : idx_inc[INDEX_W-1:0];
						frac_q   <= phase_sum[FRAC_W-1:0];
						cnt_q    <= cnt_q + 4'd1;
						if (carry != 5'd0)
							skip_q <= SKIP_W'(carry - 5'd1);
						if (done)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			abs_l_q <= abs_in_l;
			abs_r_q <= abs_in_r;
			neg_l_q <= in_l[SAMPLE_W-1];
			neg_r_q <= src_r[SAMPLE_W-1];
			scope_q <= sum_adj[SAMPLE_W:1];
		end
		if (state_q == ST_MUL_L || state_q == ST_MUL_R)
			mag_q <= prod[MAG_W-1:0];
		if (state_q == ST_DIV_L)
			ql_q <= quot;
		if (state_q == ST_DIV_R)
			qr_q <= quot;
		if (emit) begin
			out_data_q <= {2'b00, peak_r_nxt, peak_l_nxt, scope_q, wr_idx_q, sr, sl};
			out_last_q <= done;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule
